@@ hw/rtl/ttb_pkg.sv @@
// Shared types, constants and multiply schedule for the triangle tangent basis block.
// Used by the interfaces, the controller, the datapath and the normalize unit.
package ttb_pkg;

   localparam int FIELD_WIDTH = 32;   // width of every input coordinate field
   localparam int OUT_WIDTH   = 16;   // width of every Q1.14 result field
   localparam int FRAC_BITS   = 14;   // fraction bits of a Q1.14 result
   localparam int MAG_KEEP    = 30;   // magnitude bits kept before squaring
   localparam int SQ_WIDTH    = 62;   // sum of three squares of 30-bit values
   localparam int ROOT_WIDTH  = 64;   // work width of the digit-by-digit root
   localparam int ROOT_STEPS  = 32;   // one result bit per step
   localparam int ROOT_OUT    = 32;   // bits of the integer root
   localparam int QUOT_BITS   = 15;   // quotient never exceeds 2^14
   localparam int DIV_WIDTH   = 46;   // dividend and shifted divisor width
   localparam int STEP_WIDTH  = 5;    // multiply schedule index width
   localparam int CNT_WIDTH   = 5;    // controller step counter width
   localparam int COMPONENTS  = 3;

   // Multiply schedule: steps up to LAST_TB_STEP form det, tangent and binormal;
   // the steps after it form the cross product of the unit tangent and binormal.
   localparam logic [STEP_WIDTH-1:0] LAST_TB_STEP  = 5'd13;
   localparam logic [STEP_WIDTH-1:0] LAST_NRM_STEP = 5'd19;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] pos_x;
      logic signed [FIELD_WIDTH-1:0] pos_y;
      logic signed [FIELD_WIDTH-1:0] pos_z;
      logic signed [FIELD_WIDTH-1:0] tex_u;
      logic signed [FIELD_WIDTH-1:0] tex_v;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] tangent_x;
      logic signed [OUT_WIDTH-1:0] tangent_y;
      logic signed [OUT_WIDTH-1:0] tangent_z;
      logic signed [OUT_WIDTH-1:0] binormal_x;
      logic signed [OUT_WIDTH-1:0] binormal_y;
      logic signed [OUT_WIDTH-1:0] binormal_z;
      logic signed [OUT_WIDTH-1:0] normal_x;
      logic signed [OUT_WIDTH-1:0] normal_y;
      logic signed [OUT_WIDTH-1:0] normal_z;
      logic                        degenerate;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DRAIN,
      ST_NLOAD,
      ST_NSHIFT,
      ST_NSQ,
      ST_NRINIT,
      ST_NROOT,
      ST_NDINIT,
      ST_NDIV,
      ST_NDSTORE,
      ST_NCAPT,
      ST_FIN
   } state_type;

   typedef enum logic [1:0] {
      VEC_TAN,
      VEC_BIN,
      VEC_NRM
   } vec_type;

   typedef enum logic [3:0] {
      OP_DU1, OP_DV1, OP_DU2, OP_DV2,
      OP_E1X, OP_E1Y, OP_E1Z,
      OP_E2X, OP_E2Y, OP_E2Z,
      OP_TQX, OP_TQY, OP_TQZ,
      OP_BQX, OP_BQY, OP_BQZ
   } opnd_type;

   typedef enum logic [3:0] {
      DST_DET,
      DST_TX, DST_TY, DST_TZ,
      DST_BX, DST_BY, DST_BZ,
      DST_NX, DST_NY, DST_NZ
   } dst_type;

   typedef enum logic [3:0] {
      NOP_IDLE,
      NOP_LOAD,
      NOP_SHIFT,
      NOP_SQUARE,
      NOP_ROOT_INIT,
      NOP_ROOT_STEP,
      NOP_DIV_INIT,
      NOP_DIV_STEP,
      NOP_DIV_STORE
   } norm_op_type;

   typedef struct packed {
      logic                  store_vtx;
      logic                  slot;
      logic                  close;
      logic                  mul_en;
      logic [STEP_WIDTH-1:0] mstep;
      vec_type               vec;
      logic                  capture;
      logic                  finish;
      logic                  degen;
   } dp_cmd_type;

   typedef struct packed {
      norm_op_type op;
      logic [1:0]  comp;
   } norm_cmd_type;

   typedef struct packed {
      logic zero;
      logic wide;
   } norm_status_type;

   function automatic opnd_type mul_opnd_a(input logic [STEP_WIDTH-1:0] step);
      opnd_type op;
      case (step)
         5'd0:    op = OP_DU1;
         5'd1:    op = OP_DU2;
         5'd2:    op = OP_DV2;
         5'd3:    op = OP_DV1;
         5'd4:    op = OP_DV2;
         5'd5:    op = OP_DV1;
         5'd6:    op = OP_DV2;
         5'd7:    op = OP_DV1;
         5'd8:    op = OP_DU1;
         5'd9:    op = OP_DU2;
         5'd10:   op = OP_DU1;
         5'd11:   op = OP_DU2;
         5'd12:   op = OP_DU1;
         5'd13:   op = OP_DU2;
         5'd14:   op = OP_TQY;
         5'd15:   op = OP_TQZ;
         5'd16:   op = OP_TQZ;
         5'd17:   op = OP_TQX;
         5'd18:   op = OP_TQX;
         5'd19:   op = OP_TQY;
         default: op = OP_DU1;
      endcase
      return op;
   endfunction

   function automatic opnd_type mul_opnd_b(input logic [STEP_WIDTH-1:0] step);
      opnd_type op;
      case (step)
         5'd0:    op = OP_DV2;
         5'd1:    op = OP_DV1;
         5'd2:    op = OP_E1X;
         5'd3:    op = OP_E2X;
         5'd4:    op = OP_E1Y;
         5'd5:    op = OP_E2Y;
         5'd6:    op = OP_E1Z;
         5'd7:    op = OP_E2Z;
         5'd8:    op = OP_E2X;
         5'd9:    op = OP_E1X;
         5'd10:   op = OP_E2Y;
         5'd11:   op = OP_E1Y;
         5'd12:   op = OP_E2Z;
         5'd13:   op = OP_E1Z;
         5'd14:   op = OP_BQZ;
         5'd15:   op = OP_BQY;
         5'd16:   op = OP_BQX;
         5'd17:   op = OP_BQZ;
         5'd18:   op = OP_BQY;
         5'd19:   op = OP_BQX;
         default: op = OP_DV2;
      endcase
      return op;
   endfunction

   // Each pair of steps lands in one destination: even step loads, odd step subtracts.
   function automatic dst_type mul_dest(input logic [STEP_WIDTH-1:0] step);
      return dst_type'(step[STEP_WIDTH-1:1]);
   endfunction

endpackage

@@ hw/rtl/ttb_req_if.sv @@
// Vertex request channel: valid, ready and one vertex payload.
// Depends on ttb_pkg for the payload type.
interface ttb_req_if;
   logic                     valid;
   logic                     ready;
   ttb_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/ttb_rsp_if.sv @@
// Result channel: valid, ready and one tangent basis payload.
// Depends on ttb_pkg for the payload type.
interface ttb_rsp_if;
   logic                     valid;
   logic                     ready;
   ttb_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/ttb_norm.sv @@
// Normalize unit: sign/magnitude split, range shift, sum of squares,
// digit-by-digit square root and restoring division. Depends on ttb_pkg.
module ttb_norm #(
   parameter int ACC_WIDTH = 67
) (
   input  logic                              clock,
   input  ttb_pkg::norm_cmd_type             cmd,
   input  logic signed [ACC_WIDTH-1:0]       vec_in [ttb_pkg::COMPONENTS],
   input  logic                              flip,
   output ttb_pkg::norm_status_type          status,
   output logic signed [ttb_pkg::OUT_WIDTH-1:0] q_out [ttb_pkg::COMPONENTS]
);

   localparam int KEEP = ttb_pkg::MAG_KEEP;
   localparam int DW   = ttb_pkg::DIV_WIDTH;
   localparam int RW   = ttb_pkg::ROOT_WIDTH;
   localparam int QB   = ttb_pkg::QUOT_BITS;

   logic [ACC_WIDTH-1:0]          mag_ff [ttb_pkg::COMPONENTS];
   logic                          neg_ff [ttb_pkg::COMPONENTS];
   logic [ttb_pkg::SQ_WIDTH-1:0]  sum_ff;
   logic [RW-1:0]                 x_ff;
   logic [RW-1:0]                 r_ff;
   logic [RW-1:0]                 bit_ff;
   logic [DW-1:0]                 rem_ff;
   logic [DW-1:0]                 cand_ff;
   logic [QB-1:0]                 quo_ff;
   logic signed [ttb_pkg::OUT_WIDTH-1:0] q_ff [ttb_pkg::COMPONENTS];

   logic [ACC_WIDTH-1:0]          mag_or;
   logic [KEEP-1:0]               sq_opnd;
   logic [2*KEEP-1:0]             sq;
   logic [RW-1:0]                 trial;
   logic                          rem_ge;

   assign mag_or      = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign status.zero = (mag_or == '0);
   assign status.wide = |mag_or[ACC_WIDTH-1:KEEP];
   assign sq_opnd     = mag_ff[cmd.comp][KEEP-1:0];
   assign sq          = (2*KEEP)'(sq_opnd) * (2*KEEP)'(sq_opnd);
   assign trial       = r_ff + bit_ff;
   assign rem_ge      = (rem_ff >= cand_ff);
   assign q_out       = q_ff;

   always_ff @(posedge clock) begin
      case (cmd.op)
         ttb_pkg::NOP_LOAD: begin
            for (int i = 0; i < ttb_pkg::COMPONENTS; i++) begin
               mag_ff[i] <= vec_in[i][ACC_WIDTH-1] ? ACC_WIDTH'(-vec_in[i])
                                                   : ACC_WIDTH'(vec_in[i]);
               neg_ff[i] <= vec_in[i][ACC_WIDTH-1] ^ flip;
            end
         end
         ttb_pkg::NOP_SHIFT: begin
            for (int i = 0; i < ttb_pkg::COMPONENTS; i++) begin
               mag_ff[i] <= mag_ff[i] >> 1;
            end
         end
         ttb_pkg::NOP_SQUARE: begin
            sum_ff <= ((cmd.comp == 2'd0) ? '0 : sum_ff) + ttb_pkg::SQ_WIDTH'(sq);
         end
         ttb_pkg::NOP_ROOT_INIT: begin
            x_ff   <= RW'(sum_ff);
            r_ff   <= '0;
            bit_ff <= RW'(1) << (RW - 2);
         end
         ttb_pkg::NOP_ROOT_STEP: begin
            if (x_ff >= trial) begin
               x_ff <= x_ff - trial;
               r_ff <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         ttb_pkg::NOP_DIV_INIT: begin
            // dividend: m * 2^14 + floor(s / 2); divisor starts at s * 2^14
            rem_ff  <= (DW'(mag_ff[cmd.comp][KEEP-1:0]) << ttb_pkg::FRAC_BITS)
                       + DW'(r_ff[ttb_pkg::ROOT_OUT-1:1]);
            cand_ff <= DW'(r_ff[ttb_pkg::ROOT_OUT-1:0]) << ttb_pkg::FRAC_BITS;
            quo_ff  <= '0;
         end
         ttb_pkg::NOP_DIV_STEP: begin
            if (rem_ge) begin
               rem_ff <= rem_ff - cand_ff;
            end
            quo_ff  <= {quo_ff[QB-2:0], rem_ge};
            cand_ff <= cand_ff >> 1;
         end
         ttb_pkg::NOP_DIV_STORE: begin
            q_ff[cmd.comp] <= neg_ff[cmd.comp] ? -ttb_pkg::OUT_WIDTH'(quo_ff)
                                               : ttb_pkg::OUT_WIDTH'(quo_ff);
         end
         default: begin
         end
      endcase
   end

endmodule

@@ hw/rtl/ttb_datapath.sv @@
// Datapath: vertex store, edge and texture deltas, shared multiplier with
// accumulator, vector registers and the result register. Depends on ttb_pkg.
module ttb_datapath #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ttb_pkg::req_payload_type      req_payload,
   input  ttb_pkg::dp_cmd_type           cmd,
   output logic                          det_zero,
   output logic signed [2*(DATA_WIDTH+1):0] norm_vec [ttb_pkg::COMPONENTS],
   output logic                          norm_flip,
   input  logic signed [ttb_pkg::OUT_WIDTH-1:0] norm_q [ttb_pkg::COMPONENTS],
   output ttb_pkg::rsp_payload_type      rsp_payload
);

   localparam int DLW = DATA_WIDTH + 1;
   localparam int PW  = 2 * DLW;
   localparam int AW  = PW + 1;
   localparam int NC  = ttb_pkg::COMPONENTS;

   logic signed [DATA_WIDTH-1:0] held_pos_ff [2][NC];
   logic signed [DATA_WIDTH-1:0] held_tex_ff [2][2];
   logic signed [DATA_WIDTH-1:0] in_pos [NC];
   logic signed [DATA_WIDTH-1:0] in_tex [2];

   logic signed [DLW-1:0] e1_ff [NC];
   logic signed [DLW-1:0] e2_ff [NC];
   logic signed [DLW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;

   logic signed [ttb_pkg::OUT_WIDTH-1:0] tq_ff [NC];
   logic signed [ttb_pkg::OUT_WIDTH-1:0] bq_ff [NC];
   logic signed [ttb_pkg::OUT_WIDTH-1:0] nq_ff [NC];

   logic signed [DLW-1:0] ops [16];
   logic signed [DLW-1:0] op_a, op_b;
   logic signed [PW-1:0]  prod_ff;
   logic [ttb_pkg::STEP_WIDTH-1:0] pstep_ff;
   logic                  pvalid_ff;
   logic signed [AW-1:0]  acc_ff;
   logic signed [AW-1:0]  acc_diff;

   logic signed [AW-1:0]  det_ff;
   logic signed [AW-1:0]  tv_ff [NC];
   logic signed [AW-1:0]  bv_ff [NC];
   logic signed [AW-1:0]  nv_ff [NC];

   ttb_pkg::rsp_payload_type rsp_payload_ff;

   // take the low coordinate bits and treat them as signed
   assign in_pos[0] = req_payload.pos_x[DATA_WIDTH-1:0];
   assign in_pos[1] = req_payload.pos_y[DATA_WIDTH-1:0];
   assign in_pos[2] = req_payload.pos_z[DATA_WIDTH-1:0];
   assign in_tex[0] = req_payload.tex_u[DATA_WIDTH-1:0];
   assign in_tex[1] = req_payload.tex_v[DATA_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.store_vtx) begin
         for (int i = 0; i < NC; i++) begin
            held_pos_ff[cmd.slot][i] <= in_pos[i];
         end
         held_tex_ff[cmd.slot][0] <= in_tex[0];
         held_tex_ff[cmd.slot][1] <= in_tex[1];
      end
      if (cmd.close) begin
         for (int i = 0; i < NC; i++) begin
            e1_ff[i] <= DLW'(held_pos_ff[1][i]) - DLW'(held_pos_ff[0][i]);
            e2_ff[i] <= DLW'(in_pos[i]) - DLW'(held_pos_ff[0][i]);
         end
         du1_ff <= DLW'(held_tex_ff[1][0]) - DLW'(held_tex_ff[0][0]);
         dv1_ff <= DLW'(held_tex_ff[1][1]) - DLW'(held_tex_ff[0][1]);
         du2_ff <= DLW'(in_tex[0]) - DLW'(held_tex_ff[0][0]);
         dv2_ff <= DLW'(in_tex[1]) - DLW'(held_tex_ff[0][1]);
      end
   end

   always_comb begin
      ops[ttb_pkg::OP_DU1] = du1_ff;
      ops[ttb_pkg::OP_DV1] = dv1_ff;
      ops[ttb_pkg::OP_DU2] = du2_ff;
      ops[ttb_pkg::OP_DV2] = dv2_ff;
      ops[ttb_pkg::OP_E1X] = e1_ff[0];
      ops[ttb_pkg::OP_E1Y] = e1_ff[1];
      ops[ttb_pkg::OP_E1Z] = e1_ff[2];
      ops[ttb_pkg::OP_E2X] = e2_ff[0];
      ops[ttb_pkg::OP_E2Y] = e2_ff[1];
      ops[ttb_pkg::OP_E2Z] = e2_ff[2];
      ops[ttb_pkg::OP_TQX] = DLW'(tq_ff[0]);
      ops[ttb_pkg::OP_TQY] = DLW'(tq_ff[1]);
      ops[ttb_pkg::OP_TQZ] = DLW'(tq_ff[2]);
      ops[ttb_pkg::OP_BQX] = DLW'(bq_ff[0]);
      ops[ttb_pkg::OP_BQY] = DLW'(bq_ff[1]);
      ops[ttb_pkg::OP_BQZ] = DLW'(bq_ff[2]);
   end

   assign op_a     = ops[ttb_pkg::mul_opnd_a(cmd.mstep)];
   assign op_b     = ops[ttb_pkg::mul_opnd_b(cmd.mstep)];
   assign acc_diff = acc_ff - AW'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else begin
         pvalid_ff <= cmd.mul_en;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= PW'(op_a) * PW'(op_b);
      pstep_ff <= cmd.mstep;
      if (pvalid_ff) begin
         if (!pstep_ff[0]) begin
            acc_ff <= AW'(prod_ff);
         end else begin
            case (ttb_pkg::mul_dest(pstep_ff))
               ttb_pkg::DST_DET: det_ff   <= acc_diff;
               ttb_pkg::DST_TX:  tv_ff[0] <= acc_diff;
               ttb_pkg::DST_TY:  tv_ff[1] <= acc_diff;
               ttb_pkg::DST_TZ:  tv_ff[2] <= acc_diff;
               ttb_pkg::DST_BX:  bv_ff[0] <= acc_diff;
               ttb_pkg::DST_BY:  bv_ff[1] <= acc_diff;
               ttb_pkg::DST_BZ:  bv_ff[2] <= acc_diff;
               ttb_pkg::DST_NX:  nv_ff[0] <= acc_diff;
               ttb_pkg::DST_NY:  nv_ff[1] <= acc_diff;
               ttb_pkg::DST_NZ:  nv_ff[2] <= acc_diff;
               default: begin
               end
            endcase
         end
      end
   end

   assign det_zero = (det_ff == '0);

   // a negative determinant flips tangent and binormal, never the normal
   always_comb begin
      norm_flip = 1'b0;
      case (cmd.vec)
         ttb_pkg::VEC_TAN: begin
            norm_vec  = tv_ff;
            norm_flip = det_ff[AW-1];
         end
         ttb_pkg::VEC_BIN: begin
            norm_vec  = bv_ff;
            norm_flip = det_ff[AW-1];
         end
         default: begin
            norm_vec = nv_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         case (cmd.vec)
            ttb_pkg::VEC_TAN: tq_ff <= norm_q;
            ttb_pkg::VEC_BIN: bq_ff <= norm_q;
            default:          nq_ff <= norm_q;
         endcase
      end
      if (cmd.finish) begin
         rsp_payload_ff.tangent_x  <= cmd.degen ? '0 : tq_ff[0];
         rsp_payload_ff.tangent_y  <= cmd.degen ? '0 : tq_ff[1];
         rsp_payload_ff.tangent_z  <= cmd.degen ? '0 : tq_ff[2];
         rsp_payload_ff.binormal_x <= cmd.degen ? '0 : bq_ff[0];
         rsp_payload_ff.binormal_y <= cmd.degen ? '0 : bq_ff[1];
         rsp_payload_ff.binormal_z <= cmd.degen ? '0 : bq_ff[2];
         rsp_payload_ff.normal_x   <= cmd.degen ? '0 : nq_ff[0];
         rsp_payload_ff.normal_y   <= cmd.degen ? '0 : nq_ff[1];
         rsp_payload_ff.normal_z   <= cmd.degen ? '0 : nq_ff[2];
         rsp_payload_ff.degenerate <= cmd.degen;
      end
   end

   assign rsp_payload = rsp_payload_ff;

endmodule

@@ hw/rtl/ttb_ctrl.sv @@
// Controller: vertex phase, handshakes, multiply schedule and normalize sequencing.
// Drives the datapath and normalize unit by command structs. Depends on ttb_pkg.
module ttb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      det_zero,
   input  ttb_pkg::norm_status_type  norm_status,
   output ttb_pkg::dp_cmd_type       dp_cmd,
   output ttb_pkg::norm_cmd_type     norm_cmd
);

   ttb_pkg::state_type             state_ff, state_in;
   logic [1:0]                     phase_ff, phase_in;
   logic [ttb_pkg::STEP_WIDTH-1:0] mstep_ff, mstep_in;
   logic [ttb_pkg::CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [1:0]                     comp_ff, comp_in;
   ttb_pkg::vec_type               vec_ff, vec_in;
   logic                           degen_ff, degen_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttb_pkg::ST_IDLE;
         phase_ff     <= '0;
         mstep_ff     <= '0;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         vec_ff       <= ttb_pkg::VEC_TAN;
         degen_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         mstep_ff     <= mstep_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         vec_ff       <= vec_in;
         degen_ff     <= degen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a closing vertex waits until the result register is free
   assign req_ready = (state_ff == ttb_pkg::ST_IDLE) && !(phase_ff[1] && rsp_valid_ff);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      mstep_in     = mstep_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      vec_in       = vec_ff;
      degen_in     = degen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      dp_cmd           = '0;
      dp_cmd.mstep     = mstep_ff;
      dp_cmd.vec       = vec_ff;
      dp_cmd.slot      = phase_ff[0];
      dp_cmd.degen     = degen_ff;
      norm_cmd.op      = ttb_pkg::NOP_IDLE;
      norm_cmd.comp    = comp_ff;

      case (state_ff)
         ttb_pkg::ST_IDLE: begin
            if (accept) begin
               if (phase_ff[1]) begin
                  dp_cmd.close = 1'b1;
                  phase_in     = '0;
                  mstep_in     = '0;
                  vec_in       = ttb_pkg::VEC_TAN;
                  degen_in     = 1'b0;
                  state_in     = ttb_pkg::ST_MUL;
               end else begin
                  dp_cmd.store_vtx = 1'b1;
                  phase_in         = phase_ff + 2'd1;
               end
            end
         end
         ttb_pkg::ST_MUL: begin
            dp_cmd.mul_en = 1'b1;
            mstep_in      = mstep_ff + 1'b1;
            if (mstep_ff == ttb_pkg::LAST_TB_STEP || mstep_ff == ttb_pkg::LAST_NRM_STEP) begin
               state_in = ttb_pkg::ST_DRAIN;
            end
         end
         ttb_pkg::ST_DRAIN: begin
            if (vec_ff == ttb_pkg::VEC_TAN && det_zero) begin
               degen_in = 1'b1;
               state_in = ttb_pkg::ST_FIN;
            end else begin
               state_in = ttb_pkg::ST_NLOAD;
            end
         end
         ttb_pkg::ST_NLOAD: begin
            norm_cmd.op = ttb_pkg::NOP_LOAD;
            state_in    = ttb_pkg::ST_NSHIFT;
         end
         ttb_pkg::ST_NSHIFT: begin
            if (norm_status.zero) begin
               degen_in = 1'b1;
               state_in = ttb_pkg::ST_FIN;
            end else if (norm_status.wide) begin
               norm_cmd.op = ttb_pkg::NOP_SHIFT;
            end else begin
               cnt_in   = '0;
               state_in = ttb_pkg::ST_NSQ;
            end
         end
         ttb_pkg::ST_NSQ: begin
            norm_cmd.op   = ttb_pkg::NOP_SQUARE;
            norm_cmd.comp = cnt_ff[1:0];
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == ttb_pkg::CNT_WIDTH'(ttb_pkg::COMPONENTS - 1)) begin
               state_in = ttb_pkg::ST_NRINIT;
            end
         end
         ttb_pkg::ST_NRINIT: begin
            norm_cmd.op = ttb_pkg::NOP_ROOT_INIT;
            cnt_in      = '0;
            state_in    = ttb_pkg::ST_NROOT;
         end
         ttb_pkg::ST_NROOT: begin
            norm_cmd.op = ttb_pkg::NOP_ROOT_STEP;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == ttb_pkg::CNT_WIDTH'(ttb_pkg::ROOT_STEPS - 1)) begin
               comp_in  = '0;
               state_in = ttb_pkg::ST_NDINIT;
            end
         end
         ttb_pkg::ST_NDINIT: begin
            norm_cmd.op = ttb_pkg::NOP_DIV_INIT;
            cnt_in      = '0;
            state_in    = ttb_pkg::ST_NDIV;
         end
         ttb_pkg::ST_NDIV: begin
            norm_cmd.op = ttb_pkg::NOP_DIV_STEP;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == ttb_pkg::CNT_WIDTH'(ttb_pkg::QUOT_BITS - 1)) begin
               state_in = ttb_pkg::ST_NDSTORE;
            end
         end
         ttb_pkg::ST_NDSTORE: begin
            norm_cmd.op = ttb_pkg::NOP_DIV_STORE;
            if (comp_ff == 2'(ttb_pkg::COMPONENTS - 1)) begin
               state_in = ttb_pkg::ST_NCAPT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ttb_pkg::ST_NDINIT;
            end
         end
         ttb_pkg::ST_NCAPT: begin
            dp_cmd.capture = 1'b1;
            case (vec_ff)
               ttb_pkg::VEC_TAN: begin
                  vec_in   = ttb_pkg::VEC_BIN;
                  state_in = ttb_pkg::ST_NLOAD;
               end
               ttb_pkg::VEC_BIN: begin
                  vec_in   = ttb_pkg::VEC_NRM;
                  state_in = ttb_pkg::ST_MUL;
               end
               default: begin
                  state_in = ttb_pkg::ST_FIN;
               end
            endcase
         end
         ttb_pkg::ST_FIN: begin
            dp_cmd.finish = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = ttb_pkg::ST_IDLE;
         end
         default: begin
            state_in = ttb_pkg::ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ttb_pkg::ST_IDLE) |-> !req_ready)
      else $error("request taken while a triangle is in progress");

   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff[1]) |=> (state_ff == ttb_pkg::ST_MUL && mstep_ff == '0))
      else $error("closing vertex did not start the multiply schedule");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ttb_pkg::ST_FIN) |=> rsp_valid_ff)
      else $error("finished triangle produced no result");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'b11)
      else $error("vertex phase out of range");

endmodule

@@ hw/rtl/triangle_tangent_basis.sv @@
// Top level of the triangle tangent basis block.
// Depends on ttb_pkg, ttb_req_if, ttb_rsp_if, ttb_ctrl, ttb_datapath and ttb_norm.
//
// Vertices arrive one transaction at a time on req_bus (position and texture
// coordinate, signed Q16.16). The first two vertices of a triangle are held;
// the third closes the triangle and starts the computation, after which
// rsp_bus carries one transaction with the unit tangent, binormal and normal
// in signed Q1.14 and a degenerate flag. From the acceptance of a closing
// vertex to a valid result the block runs 14 multiplies through the single
// shared multiplier and a drain, then for each of the three vectors a load,
// a range shift of one bit per cycle (none for the normal) and a check, the
// squaring of the three components, a root setup, a digit-by-digit square
// root and three restoring divisions (setup, 15 quotient bits, store) and a
// capture, plus 6 multiplies and a drain for the cross product, and a finish.
// A degenerate triangle exits early. The result register lets the next two
// vertices be taken while a result waits; the next closing vertex waits
// until the result has been taken.
module triangle_tangent_basis #(
   parameter int COORD_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   ttb_req_if.sink      req_bus,
   ttb_rsp_if.source    rsp_bus
);

   // coordinates are sign-extended from at most the field width
   localparam int DATA_WIDTH = (COORD_WIDTH < ttb_pkg::FIELD_WIDTH) ? COORD_WIDTH
                                                                    : ttb_pkg::FIELD_WIDTH;
   localparam int ACC_WIDTH  = 2 * (DATA_WIDTH + 1) + 1;

   ttb_pkg::dp_cmd_type       dp_cmd;
   ttb_pkg::norm_cmd_type     norm_cmd;
   ttb_pkg::norm_status_type  norm_status;
   logic                      det_zero;
   logic                      norm_flip;
   logic signed [ACC_WIDTH-1:0]          norm_vec [ttb_pkg::COMPONENTS];
   logic signed [ttb_pkg::OUT_WIDTH-1:0] norm_q   [ttb_pkg::COMPONENTS];

   // sequence the handshakes and every datapath step
   ttb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_ready   (req_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .det_zero    (det_zero),
      .norm_status (norm_status),
      .dp_cmd      (dp_cmd),
      .norm_cmd    (norm_cmd)
   );

   // hold vertices, form deltas and products, hold the result
   ttb_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_bus.payload),
      .cmd         (dp_cmd),
      .det_zero    (det_zero),
      .norm_vec    (norm_vec),
      .norm_flip   (norm_flip),
      .norm_q      (norm_q),
      .rsp_payload (rsp_bus.payload)
   );

   // scale one vector at a time to unit length
   ttb_norm #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_norm (
      .clock  (clock),
      .cmd    (norm_cmd),
      .vec_in (norm_vec),
      .flip   (norm_flip),
      .status (norm_status),
      .q_out  (norm_q)
   );

endmodule
